>>> hdl/ctpl_pkg.sv
// shared constants for the compact trie prefix lookup core
`default_nettype none
package ctpl_pkg;
	localparam int TRIE_WORDS   = 16384;
	localparam int TRIE_AW      = $clog2(TRIE_WORDS);
	localparam int BYTE_AW      = TRIE_AW + 2;
	localparam int STRING_BYTES = 256;
	localparam int STR_AW       = $clog2(STRING_BYTES);
	localparam int POS_W        = STR_AW + 1;
	localparam int VISIT_LIMIT  = STRING_BYTES + 1;
	localparam int VIS_W        = $clog2(VISIT_LIMIT + 1);

	localparam logic [1:0] ACT_WORD   = 2'd0;
	localparam logic [1:0] ACT_BYTE   = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	typedef logic [BYTE_AW-1:0] boff_t;
	typedef logic [POS_W-1:0]   pos_t;
endpackage
`default_nettype wire

>>> hdl/compact_trie_prefix_lookup_core.sv
// compact trie prefix lookup core: sequencer over trie word memory and string buffer
//
// A word or byte write is taken in the idle state and leaves busy low. A lookup walks nodes
// one after another, and every trie byte is fetched through a request and a data state on the
// single trie memory port. Each visited node compares its prefix bytes and runs two key
// searches, and a search that hits also fetches the slot word. A prefix mismatch ends the
// walk at that byte. The length of a lookup depends on the stored data. busy is high from
// the accepted start beat until the result beat; the result shows for one cycle on done and
// cannot be held off by the receiver.
`default_nettype none
module compact_trie_prefix_lookup_core import ctpl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [13:0] word_address,
	input  wire logic [31:0] word_data,
	input  wire logic [7:0]  byte_position,
	input  wire logic [7:0]  byte_value,
	input  wire logic [8:0]  string_length,
	input  wire logic signed [14:0] start_node,
	input  wire logic [8:0]  start_position,
	output logic             done,
	output logic             found,
	output logic signed [31:0] content,
	output logic signed [14:0] next_node,
	output logic [8:0]       next_position
);
	localparam logic [4:0] S_IDLE = 5'd0,  S_VCHK = 5'd1,  S_FREQ = 5'd2,  S_FDAT = 5'd3,
		S_LGOT = 5'd4,  S_PCMP = 5'd5,  S_PEND = 5'd6,  S_SGOT = 5'd7,  S_CGOT = 5'd8,
		S_DREQ = 5'd9,  S_DDAT = 5'd10, S_DCALC = 5'd11, S_SSCHK = 5'd12, S_SSGOT = 5'd13,
		S_SUBGOT = 5'd14, S_CSINIT = 5'd15, S_CSCHK = 5'd16, S_CSGOT = 5'd17,
		S_CONGOT = 5'd18, S_AFTER = 5'd19, S_DONE = 5'd20;

	logic [4:0]         state_q, ret_q;
	logic [TRIE_AW-1:0] node_q, next_q;
	logic               node_neg_q, next_neg_q;
	pos_t               pos_q, slen_q;
	logic [VIS_W-1:0]   visits_q;
	boff_t              foff_q, cnt_q, skey_q, ckey_q, sub_q, con_q;
	logic [1:0]         fidx_q, flast_q, lane_q;
	logic [31:0]        facc_q, val_q;
	logic [7:0]         n_q, k_q;
	logic [7:0]         db_q [4];
	logic [20:0]        ch_q;
	logic [15:0]        sc_q, cc_q, mid_q;
	logic [16:0]        lo_q, hip_q;
	logic               found_q;
	logic [31:0]        content_q;

	logic               t_we, s_we;
	logic [TRIE_AW-1:0] t_addr;
	logic [31:0]        t_rd;
	logic [STR_AW-1:0]  s_addr;
	logic [7:0]         s_rd;
	boff_t              fbyte;
	logic [POS_W:0]     spos;
	logic               s_in;
	logic [7:0]         s_byte, t_byte;
	logic [16:0]        mid_sum;
	logic [20:0]        cp;
	logic [2:0]         clen;
	logic [20:0]        lc;
	logic [POS_W:0]     adv_n, adv_c;
	pos_t               slen_c, spos_c;
	boff_t              ckey_c, sub_c;

	assign busy = (state_q != S_IDLE);
	assign t_we = (state_q == S_IDLE) && start && (action == ACT_WORD);
	assign s_we = (state_q == S_IDLE) && start && (action == ACT_BYTE);
	assign fbyte = {node_q, 2'b00} + foff_q + boff_t'(fidx_q);
	assign t_addr = t_we ? word_address : fbyte[BYTE_AW-1:2];
	assign spos = {1'b0, pos_q} + {{(POS_W-7){1'b0}}, k_q};
	assign s_in = spos < {1'b0, slen_q};
	assign s_addr = s_we ? byte_position : spos[STR_AW-1:0];
	assign s_byte = s_in ? s_rd : 8'd0;
	assign t_byte = t_rd[8*lane_q +: 8];
	assign mid_sum = lo_q + hip_q - 17'd1;

	ctpl_ram #(.WIDTH(32), .DEPTH(TRIE_WORDS)) u_trie (
		.clk(clk), .we(t_we), .addr(t_addr), .wdata(word_data), .rdata(t_rd));
	ctpl_ram #(.WIDTH(8), .DEPTH(STRING_BYTES)) u_str (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(byte_value), .rdata(s_rd));

	always_comb begin
		cp = {13'd0, db_q[0]};
		clen = 3'd1;
		if (db_q[0][7:5] == 3'b110) begin
			cp = {10'd0, db_q[0][4:0], db_q[1][5:0]};
			clen = 3'd2;
		end else if (db_q[0][7:4] == 4'b1110) begin
			cp = {5'd0, db_q[0][3:0], db_q[1][5:0], db_q[2][5:0]};
			clen = 3'd3;
		end else if (db_q[0][7:3] == 5'b11110) begin
			cp = {db_q[0][2:0], db_q[1][5:0], db_q[2][5:0], db_q[3][5:0]};
			clen = 3'd4;
		end
		lc = cp;
		if ((cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'hC0 && cp <= 21'hDE && cp != 21'hD7)) begin
			lc = cp + 21'd32;
		end
		adv_n = {1'b0, pos_q} + {2'b00, n_q};
		adv_c = {1'b0, pos_q} + {{(POS_W-2){1'b0}}, clen};
		slen_c = (string_length > 9'(STRING_BYTES)) ? pos_t'(STRING_BYTES) : string_length;
		spos_c = (start_position > 9'(STRING_BYTES)) ? pos_t'(STRING_BYTES) : start_position;
		ckey_c = cnt_q + boff_t'(4) + {sc_q[BYTE_AW-2:0], 1'b0};
		sub_c = (ckey_c + {cc_q[BYTE_AW-2:0], 1'b0} + boff_t'(3)) & ~boff_t'(3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start && action == ACT_LOOKUP) begin
						slen_q <= slen_c;
						pos_q <= spos_c;
						node_q <= start_node[TRIE_AW-1:0];
						node_neg_q <= start_node[14];
						visits_q <= '0;
						found_q <= 1'b0;
						content_q <= '1;
						state_q <= S_VCHK;
					end
				end
				S_VCHK: begin
					if (node_neg_q || visits_q == VIS_W'(VISIT_LIMIT)) begin
						state_q <= S_DONE;
					end else begin
						visits_q <= visits_q + 1'b1;
						foff_q <= '0; flast_q <= 2'd0; fidx_q <= 2'd0; facc_q <= '0;
						ret_q <= S_LGOT; state_q <= S_FREQ;
					end
				end
				S_FREQ: begin
					lane_q <= fbyte[1:0];
					state_q <= S_FDAT;
				end
				S_FDAT: begin
					facc_q[8*fidx_q +: 8] <= t_byte;
					if (fidx_q == flast_q) begin
						state_q <= ret_q;
					end else begin
						fidx_q <= fidx_q + 1'b1;
						state_q <= S_FREQ;
					end
				end
				S_LGOT: begin
					n_q <= facc_q[7:0];
					k_q <= '0;
					if (facc_q[7:0] == 8'd0) begin
						state_q <= S_PEND;
					end else begin
						foff_q <= boff_t'(1); flast_q <= 2'd0; fidx_q <= 2'd0; facc_q <= '0;
						ret_q <= S_PCMP; state_q <= S_FREQ;
					end
				end
				S_PCMP: begin
					if (s_byte != facc_q[7:0]) begin
						state_q <= S_DONE;
					end else if (s_byte == 8'd0 || k_q == n_q - 8'd1) begin
						state_q <= S_PEND;
					end else begin
						k_q <= k_q + 8'd1;
						foff_q <= boff_t'(k_q) + boff_t'(2);
						flast_q <= 2'd0; fidx_q <= 2'd0; facc_q <= '0;
						ret_q <= S_PCMP; state_q <= S_FREQ;
					end
				end
				S_PEND: begin
					pos_q <= (adv_n > (POS_W+1)'(STRING_BYTES)) ? pos_t'(STRING_BYTES)
						: adv_n[POS_W-1:0];
					cnt_q <= (boff_t'(n_q) + boff_t'(2)) & ~boff_t'(1);
					foff_q <= (boff_t'(n_q) + boff_t'(2)) & ~boff_t'(1);
					flast_q <= 2'd1; fidx_q <= 2'd0; facc_q <= '0;
					ret_q <= S_SGOT; state_q <= S_FREQ;
				end
				S_SGOT: begin
					sc_q <= facc_q[15:0];
					foff_q <= cnt_q + boff_t'(2);
					flast_q <= 2'd1; fidx_q <= 2'd0; facc_q <= '0;
					ret_q <= S_CGOT; state_q <= S_FREQ;
				end
				S_CGOT: begin
					cc_q <= facc_q[15:0];
					state_q <= S_DREQ;
					k_q <= '0;
				end
				S_DREQ: begin
					if (k_q == 8'd0) begin
						skey_q <= cnt_q + boff_t'(4);
						ckey_q <= ckey_c;
						sub_q <= sub_c;
						con_q <= sub_c + {sc_q[BYTE_AW-3:0], 2'b00};
					end
					state_q <= S_DDAT;
				end
				S_DDAT: begin
					db_q[k_q[1:0]] <= s_byte;
					if (k_q == 8'd3) begin
						state_q <= S_DCALC;
					end else begin
						k_q <= k_q + 8'd1;
						state_q <= S_DREQ;
					end
				end
				S_DCALC: begin
					k_q <= '0;
					ch_q <= lc;
					pos_q <= (adv_c > (POS_W+1)'(STRING_BYTES)) ? pos_t'(STRING_BYTES)
						: adv_c[POS_W-1:0];
					lo_q <= '0;
					hip_q <= {1'b0, sc_q};
					next_neg_q <= 1'b1;
					state_q <= S_SSCHK;
				end
				S_SSCHK, S_CSCHK: begin
					if (lo_q < hip_q) begin
						mid_q <= mid_sum[16:1];
						foff_q <= ((state_q == S_SSCHK) ? skey_q : ckey_q)
							+ {mid_sum[BYTE_AW-1:1], 1'b0};
						flast_q <= 2'd1; fidx_q <= 2'd0; facc_q <= '0;
						ret_q <= (state_q == S_SSCHK) ? S_SSGOT : S_CSGOT;
						state_q <= S_FREQ;
					end else begin
						state_q <= (state_q == S_SSCHK) ? S_CSINIT : S_AFTER;
					end
				end
				S_SSGOT, S_CSGOT: begin
					if (ch_q < {5'd0, facc_q[15:0]}) begin
						hip_q <= {1'b0, mid_q};
						state_q <= (state_q == S_SSGOT) ? S_SSCHK : S_CSCHK;
					end else if (ch_q > {5'd0, facc_q[15:0]}) begin
						lo_q <= {1'b0, mid_q} + 17'd1;
						state_q <= (state_q == S_SSGOT) ? S_SSCHK : S_CSCHK;
					end else begin
						foff_q <= ((state_q == S_SSGOT) ? sub_q : con_q)
							+ {mid_q[BYTE_AW-3:0], 2'b00};
						flast_q <= 2'd3; fidx_q <= 2'd0; facc_q <= '0;
						ret_q <= (state_q == S_SSGOT) ? S_SUBGOT : S_CONGOT;
						state_q <= S_FREQ;
					end
				end
				S_SUBGOT: begin
					next_neg_q <= facc_q[31];
					next_q <= facc_q[TRIE_AW-1:0];
					state_q <= S_CSINIT;
				end
				S_CSINIT: begin
					lo_q <= '0;
					hip_q <= {1'b0, cc_q};
					val_q <= '1;
					state_q <= S_CSCHK;
				end
				S_CONGOT: begin
					val_q <= facc_q;
					state_q <= S_AFTER;
				end
				S_AFTER: begin
					node_q <= next_q;
					node_neg_q <= next_neg_q;
					if (val_q != '1) begin
						found_q <= 1'b1;
						content_q <= val_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_VCHK;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = (state_q == S_DONE);
	assign found = found_q;
	assign content = content_q;
	assign next_node = node_neg_q ? 15'sh7FFF : $signed({1'b0, node_q});
	assign next_position = pos_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result beat longer than one cycle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_LOOKUP) |=> busy)
		else $error("lookup beat not taken");
	a_found_content: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (content != -32'sd1))
		else $error("hit with empty content");
	a_miss_content: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (content == -32'sd1))
		else $error("miss with content");
endmodule
`default_nettype wire

>>> hdl/ctpl_ram.sv
// generic single port ram with registered read
`default_nettype none
module ctpl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

>>> test/compact_trie_prefix_lookup_core_tb.sv
// self-checking testbench for the compact trie prefix lookup core
`timescale 1ns / 1ps
module compact_trie_prefix_lookup_core_tb;
	import ctpl_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int unsigned NOT_FOUND = 32'hffffffff;
	localparam int RUN_LIMIT = 20000000;
	localparam int RANDOM_ITEMS = 1600;
	localparam int KEY_POOL [12] = '{0, 'h61, 'h62, 'h63, 'h64, 'h65, 'h66, 'h7a,
		'he4, 'hf6, 'h3b1, 'h20ac};

	typedef struct {
		logic [1:0]  action;
		logic [13:0] waddr;
		logic [31:0] wdata;
		logic [7:0]  bpos;
		logic [7:0]  bval;
		logic [8:0]  slen;
		logic [14:0] snode;
		logic [8:0]  spos;
	} beat_t;

	typedef struct {
		logic        found;
		logic [31:0] content;
		logic [14:0] nnode;
		logic [8:0]  npos;
	} answer_t;

	typedef struct {
		beat_t   b;
		bit      fixed;
		answer_t a;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] action = '0;
	logic [13:0] word_address = '0;
	logic [31:0] word_data = '0;
	logic [7:0] byte_position = '0;
	logic [7:0] byte_value = '0;
	logic [8:0] string_length = '0;
	logic signed [14:0] start_node = '0;
	logic [8:0] start_position = '0;
	logic done;
	logic found;
	logic signed [31:0] content;
	logic signed [14:0] next_node;
	logic [8:0] next_position;

	logic [31:0] trie_mem [TRIE_WORDS];
	logic [7:0] str_mem [STRING_BYTES];
	answer_t lookup_answers [$];
	answer_t head;
	int errors = 0;
	int cycles = 0;
	int sent = 0;
	bit steady = 1'b1;
	int unsigned free_w;

	compact_trie_prefix_lookup_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.word_address(word_address), .word_data(word_data), .byte_position(byte_position),
		.byte_value(byte_value), .string_length(string_length), .start_node(start_node),
		.start_position(start_position), .done(done), .found(found), .content(content),
		.next_node(next_node), .next_position(next_position)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// trie and string access
	function automatic logic [7:0] trie_at(int unsigned node, int unsigned off);
		int unsigned a;
		a = (node * 4 + off) % (4 * TRIE_WORDS);
		return trie_mem[a / 4][8 * (a % 4) +: 8];
	endfunction

	function automatic int unsigned trie_u16(int unsigned node, int unsigned off);
		return {trie_at(node, off + 1), trie_at(node, off)};
	endfunction

	function automatic logic [31:0] trie_u32(int unsigned node, int unsigned off);
		return {trie_at(node, off + 3), trie_at(node, off + 2), trie_at(node, off + 1),
			trie_at(node, off)};
	endfunction

	function automatic int unsigned str_at(int unsigned p, int unsigned slen);
		return (p < slen) ? str_mem[p[7:0]] : 0;
	endfunction

	function automatic int unsigned step_pos(int unsigned p, int unsigned n);
		return (p + n > STRING_BYTES) ? STRING_BYTES : p + n;
	endfunction

	function automatic int unsigned utf8_at(int unsigned p, int unsigned slen,
			output int unsigned len);
		int unsigned lead;
		lead = str_at(p, slen);
		len = 1;
		if (lead >= 'h80 && (lead >> 5) == 'h6) begin
			len = 2;
			return ((lead << 6) & 'h7ff) + (str_at(p + 1, slen) & 'h3f);
		end
		if ((lead >> 4) == 'he) begin
			len = 3;
			return ((lead << 12) & 'hffff) + ((str_at(p + 1, slen) << 6) & 'hfff)
				+ (str_at(p + 2, slen) & 'h3f);
		end
		if ((lead >> 3) == 'h1e) begin
			len = 4;
			return ((lead << 18) & 'h1fffff) + ((str_at(p + 1, slen) << 12) & 'h3ffff)
				+ ((str_at(p + 2, slen) << 6) & 'hfff) + (str_at(p + 3, slen) & 'h3f);
		end
		return lead;
	endfunction

	function automatic int unsigned fold_case(int unsigned c);
		if (c >= 'h41 && c <= 'h5a)
			return c + 32;
		if (c >= 'hc0 && c <= 'hde && c != 'hd7)
			return c + 32;
		return c;
	endfunction

	function automatic int find_key(int unsigned node, int unsigned off, int unsigned cnt,
			int unsigned c);
		int lo;
		int hi;
		int mid;
		int unsigned k;
		lo = 0;
		hi = int'(cnt) - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			k = trie_u16(node, off + 2 * mid);
			if (c < k)
				hi = mid - 1;
			else if (c > k)
				lo = mid + 1;
			else
				return mid;
		end
		return -1;
	endfunction

	// applies one beat to the shadow state and works out its answer, if any
	function automatic bit walk_trie(input beat_t b, output answer_t r);
		int unsigned slen, pos, n, k, cnt_off, ns, nc, skey, ckey, sub_off, con_off;
		int unsigned c, len, visits, sa, ta;
		logic [31:0] raw, val;
		int node, nxt, si, ci;
		bit ok, hit;
		r = '{1'b0, NOT_FOUND, 15'h7fff, 9'd0};
		if (b.action == ACT_WORD) begin
			trie_mem[b.waddr] = b.wdata;
			return 1'b0;
		end
		if (b.action == ACT_BYTE) begin
			str_mem[b.bpos] = b.bval;
			return 1'b0;
		end
		if (b.action != ACT_LOOKUP)
			return 1'b0;
		slen = (b.slen > STRING_BYTES) ? STRING_BYTES : b.slen;
		pos = (b.spos > STRING_BYTES) ? STRING_BYTES : b.spos;
		node = b.snode[14] ? -1 : int'(b.snode[13:0]);
		hit = 1'b0;
		visits = 0;
		while (node >= 0 && visits < VISIT_LIMIT && !hit) begin
			visits++;
			n = trie_at(node, 0);
			ok = 1'b1;
			for (k = 0; k < n; k++) begin
				sa = str_at(pos + k, slen);
				ta = trie_at(node, 1 + k);
				if (sa != ta) begin
					ok = 1'b0;
					break;
				end
				if (sa == 0)
					break;
			end
			if (!ok)
				break;
			pos = step_pos(pos, n);
			cnt_off = (n + 2) & ~32'd1;
			ns = trie_u16(node, cnt_off);
			nc = trie_u16(node, cnt_off + 2);
			skey = cnt_off + 4;
			ckey = skey + 2 * ns;
			sub_off = (ckey + 2 * nc + 3) & ~32'd3;
			con_off = sub_off + 4 * ns;
			c = fold_case(utf8_at(pos, slen, len));
			pos = step_pos(pos, len);
			nxt = -1;
			si = find_key(node, skey, ns, c);
			if (si >= 0) begin
				raw = trie_u32(node, sub_off + 4 * si);
				nxt = raw[31] ? -1 : int'(raw % TRIE_WORDS);
			end
			val = NOT_FOUND;
			ci = find_key(node, ckey, nc, c);
			if (ci >= 0)
				val = trie_u32(node, con_off + 4 * ci);
			node = nxt;
			if (val != NOT_FOUND) begin
				hit = 1'b1;
				r.found = 1'b1;
				r.content = val;
			end
		end
		r.nnode = 15'(node);
		r.npos = 9'(pos);
		return 1'b1;
	endfunction

	function automatic beat_t wr(int unsigned addr, logic [31:0] data);
		return '{ACT_WORD, 14'(addr), data, 8'($urandom), 8'($urandom), 9'($urandom),
			15'($urandom), 9'($urandom)};
	endfunction

	function automatic beat_t by(int unsigned p, logic [7:0] v);
		return '{ACT_BYTE, 14'($urandom), 32'($urandom), 8'(p), v, 9'($urandom),
			15'($urandom), 9'($urandom)};
	endfunction

	function automatic beat_t lk(logic [14:0] nd, int unsigned slen, int unsigned p);
		return '{ACT_LOOKUP, 14'($urandom), 32'($urandom), 8'($urandom), 8'($urandom),
			9'(slen), nd, 9'(p)};
	endfunction

	function automatic beat_t nop();
		return '{ACT_NONE, 14'($urandom), 32'($urandom), 8'($urandom), 8'($urandom),
			9'($urandom), 15'($urandom), 9'($urandom)};
	endfunction

	function automatic answer_t ans(bit f, int c, int nd, int p);
		return '{f, 32'(c), 15'(nd), 9'(p)};
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	task automatic send(input beat_t b, input bit fixed, input answer_t a);
		answer_t got;
		int g;
		@(negedge clk);
		action = b.action;
		word_address = b.waddr;
		word_data = b.wdata;
		byte_position = b.bpos;
		byte_value = b.bval;
		string_length = b.slen;
		start_node = b.snode;
		start_position = b.spos;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		if (walk_trie(b, got))
			lookup_answers.push_back(fixed ? a : got);
		if (b.action != ACT_NONE)
			sent++;
		g = steady ? 0 : gap_len();
		if (g > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic put(input beat_t b);
		send(b, 1'b0, ans(0, 0, 0, 0));
	endtask

	function automatic logic [7:0] prefix_byte();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hc3;
		return 8'h61 + 8'($urandom_range(0, 7));
	endfunction

	task automatic pick_keys(input int unsigned cnt, output int q[$]);
		int k, i, at;
		bit dup;
		q.delete();
		while (q.size() < cnt) begin
			k = KEY_POOL[$urandom_range(0, 11)];
			dup = 1'b0;
			at = q.size();
			for (i = q.size() - 1; i >= 0; i--) begin
				if (q[i] == k)
					dup = 1'b1;
				if (q[i] > k)
					at = i;
			end
			if (!dup)
				q.insert(at, k);
		end
	endtask

	// builds a small random subtree, children first, and writes it word by word
	task automatic grow(input int depth, output int unsigned at);
		logic [7:0] img[$];
		int skeys[$], ckeys[$];
		logic [31:0] sidx[$], cval[$];
		int unsigned n, ns, nc, off, kid, i;
		int r;
		n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
		ns = (depth < 2) ? $urandom_range(0, 3) : 0;
		nc = $urandom_range(ns == 0 ? 1 : 0, 3);
		pick_keys(ns, skeys);
		pick_keys(nc, ckeys);
		off = (((n + 2) & ~32'd1) + 4 + 2 * (ns + nc) + 3) & ~32'd3;
		off += 4 * (ns + nc);
		at = free_w;
		free_w = (free_w + off / 4) % TRIE_WORDS;
		for (i = 0; i < ns; i++) begin
			grow(depth + 1, kid);
			sidx.push_back(($urandom_range(0, 19) == 0) ? {1'b1, 31'($urandom)} : kid);
		end
		for (i = 0; i < nc; i++) begin
			r = $urandom_range(0, 9);
			if (r < 2)
				cval.push_back(NOT_FOUND);
			else if (r == 2)
				cval.push_back($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
			else
				cval.push_back($urandom);
		end
		img.push_back(8'(n));
		for (i = 0; i < n; i++)
			img.push_back(prefix_byte());
		while (img.size() % 2)
			img.push_back(8'h00);
		img.push_back(8'(ns));
		img.push_back(8'(ns >> 8));
		img.push_back(8'(nc));
		img.push_back(8'(nc >> 8));
		foreach (skeys[j]) begin
			img.push_back(8'(skeys[j]));
			img.push_back(8'(skeys[j] >> 8));
		end
		foreach (ckeys[j]) begin
			img.push_back(8'(ckeys[j]));
			img.push_back(8'(ckeys[j] >> 8));
		end
		while (img.size() % 4)
			img.push_back(8'h00);
		foreach (sidx[j])
			for (i = 0; i < 4; i++)
				img.push_back(sidx[j][8 * i +: 8]);
		foreach (cval[j])
			for (i = 0; i < 4; i++)
				img.push_back(cval[j][8 * i +: 8]);
		for (i = 0; i < img.size(); i += 4)
			put(wr((at + i / 4) % TRIE_WORDS, {img[i + 3], img[i + 2], img[i + 1], img[i]}));
	endtask

	task automatic emit_char(input int unsigned cp, inout logic [7:0] s[$]);
		if ((cp >= 'h61 && cp <= 'h7a) || (cp >= 'he0 && cp <= 'hfe && cp != 'hf7))
			if ($urandom_range(0, 1))
				cp -= 32;
		if (cp < 'h80) begin
			s.push_back(8'(cp));
		end else if (cp < 'h800) begin
			s.push_back(8'('hc0 | (cp >> 6)));
			s.push_back(8'('h80 | (cp & 'h3f)));
		end else if (cp < 'h10000) begin
			s.push_back(8'('he0 | (cp >> 12)));
			s.push_back(8'('h80 | ((cp >> 6) & 'h3f)));
			s.push_back(8'('h80 | (cp & 'h3f)));
		end else begin
			s.push_back(8'('hf0 | (cp >> 18)));
			s.push_back(8'('h80 | ((cp >> 12) & 'h3f)));
			s.push_back(8'('h80 | ((cp >> 6) & 'h3f)));
			s.push_back(8'('h80 | (cp & 'h3f)));
		end
	endtask

	// follows the stored trie to compose a string that mostly walks it, then looks it up
	task automatic query(input int unsigned root);
		logic [7:0] s[$];
		logic [31:0] raw;
		int node;
		int unsigned n, i, off, ns, nc, pick, hops, p0, len, slen, spos;
		int r;
		node = root;
		hops = 0;
		while (node >= 0 && hops < 6 && s.size() < 40) begin
			hops++;
			n = trie_at(node, 0);
			if (n > 40)
				break;
			for (i = 0; i < n; i++)
				s.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : trie_at(node, 1 + i));
			off = (n + 2) & ~32'd1;
			ns = trie_u16(node, off);
			nc = trie_u16(node, off + 2);
			if (ns + nc == 0 || ns + nc > 16 || $urandom_range(0, 9) == 0) begin
				node = -1;
				r = $urandom_range(0, 5);
				case (r)
					0: emit_char($urandom_range('h41, 'h5a), s);
					1: emit_char($urandom_range('hc0, 'hff), s);
					2: emit_char($urandom_range('h80, 'h7ff), s);
					3: emit_char($urandom_range('h800, 'hffff), s);
					4: emit_char($urandom_range('h10000, 'h10ffff), s);
					default: s.push_back($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hbf))
						: 8'($urandom_range('hf8, 'hff)));
				endcase
			end else begin
				pick = $urandom_range(0, ns + nc - 1);
				emit_char(trie_u16(node, off + 4 + 2 * pick), s);
				if (pick < ns) begin
					raw = trie_u32(node, ((off + 4 + 2 * (ns + nc) + 3) & ~32'd3) + 4 * pick);
					node = raw[31] ? -1 : int'(raw % TRIE_WORDS);
				end else begin
					node = -1;
				end
			end
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) s.push_back(8'($urandom));
		len = s.size();
		p0 = $urandom_range(0, STRING_BYTES - len);
		for (i = 0; i < len; i++)
			put(by(p0 + i, s[i]));
		r = $urandom_range(0, 9);
		if (r < 7)
			slen = p0 + len;
		else if (r == 7)
			slen = $urandom_range(p0, p0 + len);
		else if (r == 8)
			slen = STRING_BYTES;
		else
			slen = $urandom_range(STRING_BYTES + 1, 511);
		spos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : p0;
		put(lk(15'(root), slen, spos));
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("compact_trie_prefix_lookup_core test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (lookup_answers.size() == 0) begin
				report("result beat with nothing pending");
			end else begin
				head = lookup_answers.pop_front();
				if (found !== head.found)
					report($sformatf("found %0b, want %0b", found, head.found));
				if (content !== head.content)
					report($sformatf("content %h, want %h", content, head.content));
				if (next_node !== head.nnode)
					report($sformatf("next_node %h, want %h", next_node, head.nnode));
				if (next_position !== head.npos)
					report($sformatf("next_position %0d, want %0d", next_position, head.npos));
			end
		end
	end

	initial begin
		row_t rows [20];
		int unsigned root;
		int r, i;
		bit paused;
		rows = '{
			'{lk(15'h7fff, 0, 5), 1, ans(0, -1, -1, 5)},
			'{lk(15'h7fff, 0, 300), 1, ans(0, -1, -1, 256)},
			'{lk(15'h4000, 511, 511), 1, ans(0, -1, -1, 256)},
			'{lk(15'd0, 0, 0), 1, ans(0, -1, -1, 1)},
			'{lk(15'd16383, 511, 256), 1, ans(0, -1, -1, 256)},
			'{nop(), 0, ans(0, 0, 0, 0)},
			'{wr(16383, 32'hffffffff), 0, ans(0, 0, 0, 0)},
			'{by(255, 8'hff), 0, ans(0, 0, 0, 0)},
			'{wr(100, 32'h00010000), 0, ans(0, 0, 0, 0)},
			'{wr(101, 32'h00000000), 0, ans(0, 0, 0, 0)},
			'{wr(102, 32'd100), 0, ans(0, 0, 0, 0)},
			'{lk(15'd100, 0, 0), 1, ans(0, -1, 100, 256)},
			'{lk(15'd16383, 0, 0), 1, ans(0, -1, 16383, 0)},
			'{wr(200, 32'h00006b01), 0, ans(0, 0, 0, 0)},
			'{wr(201, 32'h00e40001), 0, ans(0, 0, 0, 0)},
			'{wr(202, 32'd42), 0, ans(0, 0, 0, 0)},
			'{by(10, 8'h6b), 0, ans(0, 0, 0, 0)},
			'{by(11, 8'hc3), 0, ans(0, 0, 0, 0)},
			'{by(12, 8'h84), 0, ans(0, 0, 0, 0)},
			'{lk(15'd200, 13, 10), 1, ans(1, 42, -1, 13)}
		};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every word and byte gets a defined value before any lookup
		for (i = 0; i < TRIE_WORDS; i++)
			put(wr(i, 32'h0));
		for (i = 0; i < STRING_BYTES; i++)
			put(by(i, 8'h00));

		steady = 1'b0;
		foreach (rows[j])
			send(rows[j].b, rows[j].fixed, rows[j].a);

		sent = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				free_w = $urandom_range(300, 15000);
				grow(0, root);
				repeat ($urandom_range(2, 6)) query(root);
			end else if (r < 80) begin
				put(lk(15'($urandom), $urandom_range(0, 511), $urandom_range(0, 511)));
			end else if (r < 90) begin
				put(wr($urandom, $urandom));
			end else if (r < 95) begin
				put(by($urandom, 8'($urandom)));
			end else begin
				put(nop());
			end
			if (!paused && sent > RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				@(negedge clk);
				start = 1'b0;
				while (lookup_answers.size() != 0)
					@(posedge clk);
				repeat (30) @(posedge clk);
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (lookup_answers.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("compact_trie_prefix_lookup_core test passed");
		else
			$display("compact_trie_prefix_lookup_core test failed");
		$finish;
	end
endmodule
